FILE: design/hlscan_pkg.sv
// ----------------------------------------------------------------------------
// hlscan_pkg
// Types, constants and the hex digit decoder shared by the hex literal scanner.
// ----------------------------------------------------------------------------
package hlscan_pkg;

  localparam int CHAR_W    = 8;
  localparam int VALUE_W   = 32;
  localparam int CNT_W     = 4;
  localparam int DIGIT_W   = 4;
  localparam int MAX_DIGITS = 8;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] OFS_NUM  = 8'd48;
  localparam logic [CHAR_W-1:0] OFS_UP   = 8'd55;
  localparam logic [CHAR_W-1:0] OFS_LO   = 8'd87;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] literal_value;
    logic [CNT_W-1:0]   digit_count;
  } lit_t;

  typedef struct packed {
    logic               is_hex;
    logic [DIGIT_W-1:0] value;
  } hex_dec_t;

  function automatic hex_dec_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_dec_t          d;
    logic [CHAR_W-1:0] diff;
    d    = '0;
    diff = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff     = c - OFS_NUM;
      d.is_hex = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      diff     = c - OFS_UP;
      d.is_hex = 1'b1;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      diff     = c - OFS_LO;
      d.is_hex = 1'b1;
    end
    d.value = diff[DIGIT_W-1:0];
    return d;
  endfunction

endpackage

FILE: design/hlscan_if.sv
// ----------------------------------------------------------------------------
// hlscan_in_if / hlscan_out_if
// Valid/ready channels carrying characters in and hex literals out.
// ----------------------------------------------------------------------------
interface hlscan_in_if import hlscan_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface hlscan_out_if import hlscan_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] literal_value;
  logic [CNT_W-1:0]   digit_count;

  modport source (output valid, output literal_value, output digit_count, input ready);
  modport sink   (input valid, input literal_value, input digit_count, output ready);
endinterface

FILE: design/hex_literal_scanner_core.sv
// ----------------------------------------------------------------------------
// hex_literal_scanner_core
// Finds hex literals introduced by 0x or 0X in a character stream and reports
// the value and digit count of each one.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_ch     in         char_byte[7:0], end_of_string
//  out_ch    out        literal_value[31:0], digit_count[3:0]
//
// One character is taken per cycle unless out_ch stalls. A literal is loaded
// into the result register, and offered on out_ch, as the scan stage consumes
// its closing character from the input register. Reset is synchronous and
// clears the history and any open literal. A stalled result register holds
// back the scan stage, and the input register fills before in_ch.ready falls.
// ----------------------------------------------------------------------------
module hex_literal_scanner_core import hlscan_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  hlscan_in_if.sink    in_ch,
  hlscan_out_if.source out_ch
);

  logic     advance;
  logic     item_valid;
  in_item_t item;
  logic     out_free;
  logic     lit_valid;
  lit_t     lit;

  hlscan_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  hlscan_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .advance    (advance),
    .lit_valid  (lit_valid),
    .lit        (lit)
  );

  hlscan_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (lit_valid),
    .lit    (lit),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

FILE: design/hlscan_in_stage.sv
// ----------------------------------------------------------------------------
// hlscan_in_stage
// Input register: holds one character until the scan logic consumes it.
// ----------------------------------------------------------------------------
module hlscan_in_stage import hlscan_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  hlscan_in_if.sink    in_ch,
  input  logic         advance,
  output logic         item_valid,
  output in_item_t     item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.char_byte     <= in_ch.char_byte;
      item_r.end_of_string <= in_ch.end_of_string;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: design/hlscan_scan.sv
// ----------------------------------------------------------------------------
// hlscan_scan
// Byte history, prefix detection and digit accumulation for one character
// per cycle while the result register can take a literal (advance).
// ----------------------------------------------------------------------------
module hlscan_scan import hlscan_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_valid,
  input  in_item_t item,
  input  logic     out_free,
  output logic     advance,
  output logic     lit_valid,
  output lit_t     lit
);

  logic [CHAR_W-1:0]  prev_r, prev_nxt;
  logic [CHAR_W-1:0]  prev2_r, prev2_nxt;
  logic               lock_r, lock_nxt;
  logic               lock2_r, lock2_nxt;
  logic               inlit_r, inlit_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]   dig_r, dig_nxt;

  hex_dec_t           dec;
  logic               prefix;
  logic               active;
  logic [CNT_W:0]     cnt;
  logic [VALUE_W-1:0] acc_shift;
  logic               cur_lock;
  logic               lock_mid;
  logic               emit;

  assign advance   = item_valid && out_free;
  assign dec       = hex_decode(item.char_byte);
  assign prefix    = (prev2_r == CH_ZERO) && ((prev_r == CH_X_LO) || (prev_r == CH_X_UP))
                     && !lock2_r;
  assign active    = inlit_r || prefix;
  assign cnt       = {1'b0, dig_r} + (CNT_W+1)'(1);
  assign acc_shift = {acc_r[VALUE_W-DIGIT_W-1:0], dec.value};

  always_comb begin
    emit      = 1'b0;
    lit       = '0;
    cur_lock  = 1'b0;
    lock_mid  = lock_r;
    inlit_nxt = 1'b0;
    acc_nxt   = '0;
    dig_nxt   = '0;
    if (active && dec.is_hex) begin
      if (cnt >= (CNT_W+1)'(MAX_DIGITS) || item.end_of_string) begin
        emit              = 1'b1;
        lit.literal_value = acc_shift;
        lit.digit_count   = cnt[CNT_W-1:0];
        cur_lock          = 1'b1;
      end else begin
        inlit_nxt = 1'b1;
        acc_nxt   = acc_shift;
        dig_nxt   = cnt[CNT_W-1:0];
      end
    end else if (inlit_r) begin
      emit              = 1'b1;
      lit.literal_value = acc_r;
      lit.digit_count   = dig_r;
      lock_mid          = 1'b1;
    end
    prev2_nxt = prev_r;
    prev_nxt  = item.char_byte;
    lock2_nxt = lock_mid;
    lock_nxt  = cur_lock;
    if (item.end_of_string) begin
      prev2_nxt = '0;
      prev_nxt  = '0;
      lock2_nxt = 1'b0;
      lock_nxt  = 1'b0;
      inlit_nxt = 1'b0;
      acc_nxt   = '0;
      dig_nxt   = '0;
    end
  end

  assign lit_valid = advance && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      prev2_r <= '0;
      lock_r  <= 1'b0;
      lock2_r <= 1'b0;
      inlit_r <= 1'b0;
      acc_r   <= '0;
      dig_r   <= '0;
    end else if (advance) begin
      prev_r  <= prev_nxt;
      prev2_r <= prev2_nxt;
      lock_r  <= lock_nxt;
      lock2_r <= lock2_nxt;
      inlit_r <= inlit_nxt;
      acc_r   <= acc_nxt;
      dig_r   <= dig_nxt;
    end
  end

endmodule

FILE: design/hlscan_out_stage.sv
// ----------------------------------------------------------------------------
// hlscan_out_stage
// Result register: holds one literal until the downstream side takes it.
// ----------------------------------------------------------------------------
module hlscan_out_stage import hlscan_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  lit_t          lit,
  output logic          free,
  hlscan_out_if.source  out_ch
);

  logic valid_r;
  logic valid_nxt;
  lit_t lit_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lit_r <= lit;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.literal_value = lit_r.literal_value;
  assign out_ch.digit_count   = lit_r.digit_count;

endmodule
